// File: rtl/core/psa_pkg.sv
package psa_pkg;

  // Table depth default
  localparam int unsigned MAX_PROCESSES_DEF = 16;

  // Field widths
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned PRI_W    = 32;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGING_STEP    = 4'd1;

  // Register reset values
  localparam logic [4:0] PROCESS_COUNT_RST = 5'd1;
  localparam logic [7:0] AGING_STEP_RST    = 8'd2;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // One process table entry
  typedef struct packed {
    logic [TIME_W-1:0]        arrival;
    logic [TIME_W-1:0]        remaining;
    logic signed [PRI_W-1:0]  pri;
    logic [TIME_W-1:0]        waiting;
  } psa_entry_t;

endpackage

// File: rtl/core/psa_table.sv
module psa_table #(
  parameter int unsigned DEPTH = psa_pkg::MAX_PROCESSES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output psa_pkg::psa_entry_t    rd_data,
  input  logic                   wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  psa_pkg::psa_entry_t    wr_data
);

  psa_pkg::psa_entry_t mem [DEPTH];
  logic [DEPTH-1:0]    wvalid_r;
  psa_pkg::psa_entry_t rd_q_r;
  logic                rd_wv_r;

  // Write the entry and read one slot per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r  <= mem[rd_addr];
    rd_wv_r <= wvalid_r[rd_addr];
  end

  // Mark waiting counts as written; unmarked ones read zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r <= '0;
    end else if (wr_en) begin
      wvalid_r[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    rd_data = rd_q_r;
    if (!rd_wv_r) begin
      rd_data.waiting = '0;
    end
  end

endmodule

// File: rtl/core/priority_scheduler_with_aging_top.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall   | operation, slot, arrival, burst, priority_req
// out_    | output    | out_valid/out_stall | run_slot, idle, finished, turnaround,
//         |           |                     | wait_total, all_done
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A load is written in ST_IDLE. A tick walks the single read port of the process table
// twice over the n slots in use, n being the slots in use: ST_PREV reads the running slot,
// ST_SCAN picks the running slot, ST_UPD ages, counts waiting and updates, ST_FIN reports.
// Reset is synchronous; waiting counts of unwritten slots read as zero through per-slot valid bits.
// in_stall is high while a tick is under way. A finished tick waits in its last
// state while an earlier result beat is still held by out_stall.
module priority_scheduler_with_aging_top #(
  parameter int unsigned MAX_PROCESSES = psa_pkg::MAX_PROCESSES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [3:0]                        in_slot,
  input  logic [15:0]                       in_arrival,
  input  logic [15:0]                       in_burst,
  input  logic signed [15:0]                in_priority_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        out_run_slot,
  output logic                              out_idle,
  output logic                              out_finished,
  output logic [15:0]                       out_turnaround,
  output logic [15:0]                       out_wait_total,
  output logic                              out_all_done,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [psa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psa_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int unsigned IDX_W = $clog2(MAX_PROCESSES);
  localparam int unsigned CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned TW    = psa_pkg::TIME_W;
  localparam int unsigned PW    = psa_pkg::PRI_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREV = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [4:0]           pc_r, pc_nxt;
  logic [7:0]           aging_r, aging_nxt;
  logic [TW-1:0]        ct_r, ct_nxt;
  logic [TW-1:0]        earliest_r, earliest_nxt;
  logic [IDX_W-1:0]     running_r, running_nxt;
  logic                 started_r, started_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic signed [PW-1:0] best_pri_r, best_pri_nxt;
  logic                 have_r, have_nxt;
  logic                 notdone_r, notdone_nxt;
  logic                 fin_r, fin_nxt;
  logic [TW-1:0]        tat_r, tat_nxt;
  logic [TW-1:0]        wt_r, wt_nxt;

  logic [3:0]           o_slot_r, o_slot_nxt;
  logic                 o_idle_r, o_idle_nxt;
  logic                 o_fin_r, o_fin_nxt;
  logic [TW-1:0]        o_tat_r, o_tat_nxt;
  logic [TW-1:0]        o_wt_r, o_wt_nxt;
  logic                 o_done_r, o_done_nxt;

  logic [IDX_W-1:0]     rd_addr;
  psa_pkg::psa_entry_t  entry;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  psa_pkg::psa_entry_t  wr_data;

  logic [CNT_W-1:0]     n_use;
  logic [IDX_W-1:0]     last_idx;
  logic [IDX_W-1:0]     cur_idx;
  logic                 in_use;
  logic                 ready_cur;
  logic                 ready_new;
  logic [TW-1:0]        ct_inc;
  logic                 is_sel;
  logic                 add_a;
  logic                 add_b;
  logic [TW:0]          w_sum;
  logic [TW-1:0]        w_new;
  logic [TW-1:0]        rem_new;
  logic signed [PW:0]   pri_dif;
  logic signed [PW-1:0] pri_new;
  logic                 in_acc;
  logic                 slot_ok;
  logic                 slot_in_use;

  psa_table #(.DEPTH(MAX_PROCESSES)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (entry),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_run_slot   = o_slot_r;
  assign out_idle       = o_idle_r;
  assign out_finished   = o_fin_r;
  assign out_turnaround = o_tat_r;
  assign out_wait_total = o_wt_r;
  assign out_all_done   = o_done_r;

  // Clamp the slot count to the table; a count of zero uses one slot
  always_comb begin
    if (pc_r == 5'd0) begin
      n_use = CNT_W'(1);
    end else if (32'(pc_r) > MAX_PROCESSES) begin
      n_use = CNT_W'(MAX_PROCESSES);
    end else begin
      n_use = CNT_W'(pc_r);
    end
  end

  assign last_idx    = IDX_W'(n_use - CNT_W'(1));
  assign slot_ok     = 32'(in_slot) < MAX_PROCESSES;
  assign slot_in_use = 32'(in_slot) < 32'(n_use);

  // Readiness of the slot whose entry is on the read port
  assign cur_idx   = (state_r == ST_PREV) ? running_r : idx_r;
  assign in_use    = 32'(cur_idx) < 32'(n_use);
  assign ct_inc    = (ct_r == psa_pkg::TIME_MAX) ? ct_r : ct_r + TW'(1);
  assign ready_cur = in_use && (entry.arrival <= ct_r) && (entry.remaining != '0);
  assign ready_new = in_use && (entry.arrival <= ct_inc) && (entry.remaining != '0);

  // Shared update unit: aging, burst and waiting for one slot
  assign is_sel  = (idx_r == best_idx_r);
  assign add_a   = (best_idx_r != running_r) && ready_cur && !is_sel;
  assign add_b   = ready_new && !is_sel;
  assign w_sum   = {1'b0, entry.waiting} + (TW+1)'(add_a) + (TW+1)'(add_b);
  assign w_new   = w_sum[TW] ? psa_pkg::TIME_MAX : w_sum[TW-1:0];
  assign rem_new = is_sel ? entry.remaining - TW'(1) : entry.remaining;
  assign pri_dif = $signed({entry.pri[PW-1], entry.pri}) - $signed({{(PW-7){1'b0}}, aging_r});
  always_comb begin
    if (is_sel) begin
      pri_new = entry.pri;
    end else if (pri_dif[PW] != pri_dif[PW-1]) begin
      pri_new = {1'b1, {(PW-1){1'b0}}};
    end else begin
      pri_new = pri_dif[PW-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    aging_nxt     = aging_r;
    ct_nxt        = ct_r;
    earliest_nxt  = earliest_r;
    running_nxt   = running_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    best_idx_nxt  = best_idx_r;
    best_pri_nxt  = best_pri_r;
    have_nxt      = have_r;
    notdone_nxt   = notdone_r;
    fin_nxt       = fin_r;
    tat_nxt       = tat_r;
    wt_nxt        = wt_r;
    o_slot_nxt    = o_slot_r;
    o_idle_nxt    = o_idle_r;
    o_fin_nxt     = o_fin_r;
    o_tat_nxt     = o_tat_r;
    o_wt_nxt      = o_wt_r;
    o_done_nxt    = o_done_r;
    rd_addr       = running_r;
    wr_en         = 1'b0;
    wr_addr       = IDX_W'(in_slot);
    wr_data       = '0;

    // Take configuration writes
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == psa_pkg::CFG_PROCESS_COUNT) begin
        pc_nxt = cfg_data[4:0];
      end else if (cfg_index == psa_pkg::CFG_AGING_STEP) begin
        aging_nxt = cfg_data;
      end
    end

    // Drop the result beat once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        rd_addr = running_r;
        if (in_acc) begin
          if (in_operation == psa_pkg::OP_LOAD) begin
            if (slot_ok) begin
              wr_en             = 1'b1;
              wr_addr           = IDX_W'(in_slot);
              wr_data.arrival   = in_arrival;
              wr_data.remaining = in_burst;
              wr_data.pri       = {{(PW-16){in_priority_req[15]}}, in_priority_req};
              wr_data.waiting   = '0;
              if (!started_r && slot_in_use && (in_arrival < earliest_r)) begin
                earliest_nxt = in_arrival;
                running_nxt  = IDX_W'(in_slot);
              end
            end
          end else begin
            if (!started_r) begin
              ct_nxt      = earliest_r;
              started_nxt = 1'b1;
            end
            state_nxt = ST_PREV;
          end
        end
      end
      ST_PREV: begin
        best_idx_nxt = running_r;
        best_pri_nxt = entry.pri;
        have_nxt     = ready_cur;
        idx_nxt      = '0;
        rd_addr      = '0;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        if (ready_cur && (!have_r || ($signed(entry.pri) < best_pri_r))) begin
          best_idx_nxt = idx_r;
          best_pri_nxt = entry.pri;
          have_nxt     = 1'b1;
        end
        if (idx_r == last_idx) begin
          idx_nxt     = '0;
          rd_addr     = '0;
          notdone_nxt = 1'b0;
          fin_nxt     = 1'b0;
          tat_nxt     = '0;
          wt_nxt      = '0;
          state_nxt   = ST_UPD;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          rd_addr = idx_r + IDX_W'(1);
        end
      end
      ST_UPD: begin
        if (have_r) begin
          wr_en             = 1'b1;
          wr_addr           = idx_r;
          wr_data.arrival   = entry.arrival;
          wr_data.remaining = rem_new;
          wr_data.pri       = pri_new;
          wr_data.waiting   = w_new;
          if (rem_new != '0) begin
            notdone_nxt = 1'b1;
          end
          if (is_sel && (rem_new == '0)) begin
            fin_nxt = 1'b1;
            tat_nxt = ct_inc - entry.arrival;
            wt_nxt  = entry.waiting;
          end
        end else if (entry.remaining != '0) begin
          notdone_nxt = 1'b1;
        end
        if (idx_r == last_idx) begin
          rd_addr   = running_r;
          state_nxt = ST_FIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          rd_addr = idx_r + IDX_W'(1);
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_slot_nxt    = have_r ? 4'(best_idx_r) : 4'd0;
          o_idle_nxt    = !have_r;
          o_fin_nxt     = fin_r;
          o_tat_nxt     = tat_r;
          o_wt_nxt      = wt_r;
          o_done_nxt    = !notdone_r;
          ct_nxt        = ct_inc;
          if (have_r) begin
            running_nxt = best_idx_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= psa_pkg::PROCESS_COUNT_RST;
      aging_r     <= psa_pkg::AGING_STEP_RST;
      ct_r        <= '0;
      earliest_r  <= psa_pkg::TIME_MAX;
      running_r   <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      aging_r     <= aging_nxt;
      ct_r        <= ct_nxt;
      earliest_r  <= earliest_nxt;
      running_r   <= running_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_pri_r <= best_pri_nxt;
    have_r     <= have_nxt;
    notdone_r  <= notdone_nxt;
    fin_r      <= fin_nxt;
    tat_r      <= tat_nxt;
    wt_r       <= wt_nxt;
    o_slot_r   <= o_slot_nxt;
    o_idle_r   <= o_idle_nxt;
    o_fin_r    <= o_fin_nxt;
    o_tat_r    <= o_tat_nxt;
    o_wt_r     <= o_wt_nxt;
    o_done_r   <= o_done_nxt;
  end

endmodule

// File: rtl/core/psa_checker.sv
module psa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_operation,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_run_slot,
  input logic        out_idle,
  input logic        out_finished,
  input logic [15:0] out_turnaround,
  input logic [15:0] out_wait_total,
  input logic        out_all_done
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_run_slot) && $stable(out_idle)
      && $stable(out_finished) && $stable(out_turnaround) && $stable(out_wait_total)
      && $stable(out_all_done))
    else $error("stalled result beat changed");

  // An idle tick reports no slot and no completion
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_idle |-> !out_finished && (out_run_slot == 4'd0))
    else $error("idle tick reports a running slot or completion");

  // Completion figures only with a finished process
  a_fin_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_finished |-> (out_turnaround == 16'd0) && (out_wait_total == 16'd0))
    else $error("completion figures without a finished process");

  // A tick keeps the input side stalled while it walks the table
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == psa_pkg::OP_TICK) |=> in_stall)
    else $error("input taken during a tick");

endmodule

bind priority_scheduler_with_aging_top psa_checker u_psa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_operation   (in_operation),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_run_slot   (out_run_slot),
  .out_idle       (out_idle),
  .out_finished   (out_finished),
  .out_turnaround (out_turnaround),
  .out_wait_total (out_wait_total),
  .out_all_done   (out_all_done)
);

// File: sim/priority_scheduler_with_aging_top_test.sv
`timescale 1ns / 1ps

module priority_scheduler_with_aging_top_test;
  import psa_pkg::*;

  localparam int unsigned SLOTS = MAX_PROCESSES_DEF;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned OPENING_LEN = 20;

  typedef struct packed {
    logic               operation;
    logic [3:0]         slot;
    logic [15:0]        arrival;
    logic [15:0]        burst;
    logic signed [15:0] priority_req;
  } sched_item_t;

  typedef struct packed {
    logic [3:0]  run_slot;
    logic        idle;
    logic        finished;
    logic [15:0] turnaround;
    logic [15:0] wait_total;
    logic        all_done;
  } sched_report_t;

  typedef struct packed {
    sched_item_t   item;
    logic          typed;
    sched_report_t want;
  } opening_row_t;

  // Opening sequence: three slots in use, aging step of two.
  // Slot 0 with no burst makes the first ticks idle; slot 1 then runs and
  // completes; later loads force a preemption and a full drain to all_done.
  localparam opening_row_t OPENING_ROWS [OPENING_LEN] = '{
    '{'{OP_LOAD, 4'd15, 16'd0,     16'd1,     16'sd0},    1'b0, '0},
    '{'{OP_LOAD, 4'd0,  16'hFFFF,  16'hFFFF,  16'sh7FFF}, 1'b0, '0},
    '{'{OP_LOAD, 4'd1,  16'd65283, 16'd2,     16'sh8000}, 1'b0, '0},
    '{'{OP_LOAD, 4'd2,  16'd65300, 16'd3,     16'sd100},  1'b0, '0},
    '{'{OP_LOAD, 4'd0,  16'd65280, 16'd0,     16'sh7FFF}, 1'b0, '0},
    '{'{OP_TICK, 4'd0,  16'd0,     16'd0,     16'sd0},    1'b1,
      '{4'd0, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0}},
    '{'{OP_TICK, 4'd0,  16'd0,     16'd0,     16'sd0},    1'b1,
      '{4'd0, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0}},
    '{'{OP_TICK, 4'd15, 16'hFFFF,  16'hFFFF,  16'sh7FFF}, 1'b1,
      '{4'd0, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0}},
    '{'{OP_TICK, 4'd0,  16'd0,     16'd0,     16'sd0},    1'b1,
      '{4'd1, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0}},
    '{'{OP_TICK, 4'd0,  16'd0,     16'd0,     16'sd0},    1'b1,
      '{4'd1, 1'b0, 1'b1, 16'd2, 16'd0, 1'b0}},
    '{'{OP_LOAD, 4'd2,  16'd0,     16'd2,     16'sd100},  1'b0, '0},
    '{'{OP_LOAD, 4'd0,  16'd65285, 16'd3,     16'sd50},   1'b0, '0},
    '{'{OP_TICK, 4'd0,  16'd0,     16'd0,     16'sd0},    1'b0, '0},
    '{'{OP_LOAD, 4'd1,  16'd65000, 16'd1,     16'sh8000}, 1'b0, '0},
    '{'{OP_TICK, 4'd0,  16'd0,     16'd0,     16'sd0},    1'b0, '0},
    '{'{OP_TICK, 4'd0,  16'd0,     16'd0,     16'sd0},    1'b0, '0},
    '{'{OP_TICK, 4'd0,  16'd0,     16'd0,     16'sd0},    1'b0, '0},
    '{'{OP_TICK, 4'd0,  16'd0,     16'd0,     16'sd0},    1'b0, '0},
    '{'{OP_TICK, 4'd0,  16'd0,     16'd0,     16'sd0},    1'b0, '0},
    '{'{OP_TICK, 4'd0,  16'd0,     16'd0,     16'sd0},    1'b1,
      '{4'd0, 1'b1, 1'b0, 16'd0, 16'd0, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_operation;
  logic [3:0] in_slot;
  logic [15:0] in_arrival;
  logic [15:0] in_burst;
  logic signed [15:0] in_priority_req;
  logic out_valid;
  logic out_stall;
  logic [3:0] out_run_slot;
  logic out_idle;
  logic out_finished;
  logic [15:0] out_turnaround;
  logic [15:0] out_wait_total;
  logic out_all_done;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // Scheduler state as predicted
  logic [15:0]        p_arrival [SLOTS];
  logic [15:0]        p_remaining [SLOTS];
  logic signed [31:0] p_pri [SLOTS];
  logic [15:0]        p_waiting [SLOTS];
  logic [15:0]        p_time;
  logic [15:0]        p_earliest;
  logic [3:0]         p_running;
  logic               p_started;
  logic [4:0]         p_count;
  logic [7:0]         p_aging;
  logic [SLOTS-1:0]   slot_written;

  sched_report_t tick_reports_due [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit long_hold_req = 1'b0;

  priority_scheduler_with_aging_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_slot         (in_slot),
    .in_arrival      (in_arrival),
    .in_burst        (in_burst),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_run_slot    (out_run_slot),
    .out_idle        (out_idle),
    .out_finished    (out_finished),
    .out_turnaround  (out_turnaround),
    .out_wait_total  (out_wait_total),
    .out_all_done    (out_all_done),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("priority_scheduler_with_aging_top regression: fail");
      $finish;
    end
  end

  function automatic int unsigned slots_used();
    if (p_count == 5'd0) return 1;
    if (p_count > 5'(SLOTS)) return SLOTS;
    return int'(p_count);
  endfunction

  function automatic bit slot_ready(int unsigned i, logic [15:0] t, int unsigned n);
    return (i < n) && (p_arrival[i] <= t) && (p_remaining[i] != 16'd0);
  endfunction

  // Count one waiting unit for every ready slot other than the runner
  function automatic void bump_waiting(int unsigned n, int unsigned run, logic [15:0] t);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      if (i != run && slot_ready(i, t, n) && p_waiting[i] != TIME_MAX)
        p_waiting[i] = p_waiting[i] + 16'd1;
    end
  endfunction

  function automatic void load_process(sched_item_t it);
    p_arrival[it.slot]   = it.arrival;
    p_remaining[it.slot] = it.burst;
    p_pri[it.slot]       = it.priority_req;
    p_waiting[it.slot]   = 16'd0;
    slot_written[it.slot] = 1'b1;
    // Track the earliest arrival only until scheduling starts
    if (!p_started && it.slot < slots_used() && it.arrival < p_earliest) begin
      p_earliest = it.arrival;
      p_running  = it.slot;
    end
  endfunction

  function automatic sched_report_t schedule_tick();
    int unsigned n;
    int unsigned i;
    int unsigned prev;
    int unsigned sel;
    bit have;
    logic [15:0] t;
    longint aged;
    sched_report_t r;
    n = slots_used();
    r = '0;
    have = 1'b0;
    if (!p_started) begin
      p_time = p_earliest;
      p_started = 1'b1;
    end
    t = p_time;
    prev = p_running;
    // Keep the runner unless a ready slot is strictly more urgent
    if (slot_ready(prev, t, n)) begin
      sel = prev;
      have = 1'b1;
    end else begin
      sel = 0;
    end
    for (i = 0; i < n; i++) begin
      if (slot_ready(i, t, n) && (!have || p_pri[i] < p_pri[sel])) begin
        sel = i;
        have = 1'b1;
      end
    end
    if (!have) begin
      if (p_time != TIME_MAX) p_time = p_time + 16'd1;
      r.idle = 1'b1;
    end else begin
      if (sel != prev) bump_waiting(n, sel, t);
      if (p_time != TIME_MAX) p_time = p_time + 16'd1;
      p_remaining[sel] = p_remaining[sel] - 16'd1;
      // Age everyone else, floored at the most negative value
      for (i = 0; i < n; i++) begin
        if (i != sel) begin
          aged = longint'(p_pri[i]) - longint'(p_aging);
          if (aged < -64'sd2147483648) aged = -64'sd2147483648;
          p_pri[i] = 32'(aged);
        end
      end
      bump_waiting(n, sel, p_time);
      p_running = 4'(sel);
      r.run_slot = 4'(sel);
      if (p_remaining[sel] == 16'd0) begin
        r.finished = 1'b1;
        r.turnaround = p_time - p_arrival[sel];
        r.wait_total = p_waiting[sel];
      end
    end
    r.all_done = 1'b1;
    for (i = 0; i < n; i++) begin
      if (p_remaining[i] != 16'd0) r.all_done = 1'b0;
    end
    return r;
  endfunction

  // Load with an arrival close to the current time and a short burst
  function automatic sched_item_t well_formed_load(int unsigned s);
    sched_item_t it;
    int a;
    a = int'(p_time);
    if ($urandom_range(3) == 0) a = a + int'($urandom_range(1, 4));
    else a = a - int'($urandom_range(24));
    if (a < 0) a = 0;
    if (a > 65535) a = 65535;
    it.operation = OP_LOAD;
    it.slot = 4'(s);
    it.arrival = 16'(a);
    it.burst = 16'($urandom_range(1, 8));
    it.priority_req = 16'($urandom_range(600)) - 16'd300;
    return it;
  endfunction

  function automatic sched_item_t random_item();
    sched_item_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      // Tick with junk in the unused fields
      it.operation = OP_TICK;
      it.slot = 4'($urandom);
      it.arrival = 16'($urandom);
      it.burst = 16'($urandom);
      it.priority_req = 16'($urandom);
    end else if (pick < 88) begin
      it = well_formed_load($urandom_range(slots_used() - 1));
    end else begin
      // Stray load: any slot, any arrival, odd bursts
      it.operation = OP_LOAD;
      it.slot = 4'($urandom);
      it.arrival = 16'($urandom);
      case ($urandom_range(5))
        0, 1: it.burst = 16'd0;
        2: it.burst = 16'hFFFF;
        default: it.burst = 16'($urandom);
      endcase
      it.priority_req = 16'($urandom);
    end
    return it;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_tick_report();
    sched_report_t want;
    if (tick_reports_due.size() == 0) begin
      $error("result beat with none due: run_slot %0d", out_run_slot);
      mismatches++;
    end else begin
      want = tick_reports_due.pop_front();
      compare_field("run_slot", 16'(want.run_slot), 16'(out_run_slot));
      compare_field("idle", 16'(want.idle), 16'(out_idle));
      compare_field("finished", 16'(want.finished), 16'(out_finished));
      compare_field("turnaround", want.turnaround, out_turnaround);
      compare_field("wait_total", want.wait_total, out_wait_total);
      compare_field("all_done", 16'(want.all_done), 16'(out_all_done));
    end
  endfunction

  // Offer one beat after a random gap and predict once it is taken
  task automatic send_beat(input sched_item_t it, input logic typed, input sched_report_t want);
    sched_report_t report;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= it.operation;
    in_slot         <= it.slot;
    in_arrival      <= it.arrival;
    in_burst        <= it.burst;
    in_priority_req <= it.priority_req;
    do @(posedge clk); while (in_stall);
    if (it.operation == OP_TICK) begin
      report = schedule_tick();
      tick_reports_due.push_back(typed ? want : report);
    end else begin
      load_process(it);
    end
  endtask

  // Drop valid and let the block go quiet
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tick_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] count_val, input logic [7:0] step_val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PROCESS_COUNT;
    cfg_data  <= count_val;
    do @(posedge clk); while (!cfg_ready);
    p_count = count_val[4:0];
    cfg_index <= CFG_AGING_STEP;
    cfg_data  <= step_val;
    do @(posedge clk); while (!cfg_ready);
    p_aging = step_val;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned beats, input logic [7:0] count_val,
                           input logic [7:0] step_val, input int unsigned gap,
                           input int unsigned stall, input bit hold);
    int unsigned s;
    drain_results();
    write_regs(count_val, step_val);
    send_gap_pct = gap;
    recv_stall_pct = stall;
    long_hold_req = hold;
    // Load any slot in use that has never been written
    for (s = 0; s < slots_used(); s++) begin
      if (!slot_written[s]) send_beat(well_formed_load(s), 1'b0, '0);
    end
    repeat (beats) send_beat(random_item(), 1'b0, '0);
  endtask

  // Result side: check accepted beats, stall at random
  initial begin : result_side
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) check_tick_report();
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin : stimulus
    int unsigned k;
    in_valid = 1'b0;
    in_operation = OP_LOAD;
    in_slot = '0;
    in_arrival = '0;
    in_burst = '0;
    in_priority_req = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PROCESS_COUNT;
    cfg_data = '0;
    rst_n = 1'b0;
    for (k = 0; k < SLOTS; k++) begin
      p_arrival[k] = '0;
      p_remaining[k] = '0;
      p_pri[k] = '0;
      p_waiting[k] = '0;
    end
    p_time = '0;
    p_earliest = TIME_MAX;
    p_running = '0;
    p_started = 1'b0;
    p_count = PROCESS_COUNT_RST;
    p_aging = AGING_STEP_RST;
    slot_written = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening table
    write_regs(8'd3, 8'd2);
    send_gap_pct = 33;
    recv_stall_pct = 72;
    for (k = 0; k < OPENING_LEN; k++)
      send_beat(OPENING_ROWS[k].item, OPENING_ROWS[k].typed, OPENING_ROWS[k].want);

    // Random phases across slot counts and aging steps
    run_phase(160, 8'd16, 8'd0, 33, 72, 1'b0);
    run_phase(160, 8'd0, 8'd255, 72, 33, 1'b0);
    run_phase(160, 8'd31, 8'd128, 72, 33, 1'b0);
    run_phase(170, 8'd5, 8'd7, 0, 0, 1'b1);

    drain_results();
    if (mismatches == 0) begin
      $display("priority_scheduler_with_aging_top regression: pass");
    end else begin
      $display("priority_scheduler_with_aging_top regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/psa_pkg.sv
rtl/core/psa_table.sv
rtl/core/priority_scheduler_with_aging_top.sv
rtl/core/psa_checker.sv
sim/priority_scheduler_with_aging_top_test.sv
